### hw/rtl/mi3_pkg.sv
// Shared widths and timing constants for the 3x3 matrix inverse pipeline.
// No dependencies; imported by every module of the block.
package mi3_pkg;

    localparam int A_W     = 16;           // input entry, Q3.12
    localparam int PROD_W  = 2 * A_W;      // product of two entries
    localparam int COF_W   = PROD_W + 1;   // cofactor, Q8.24
    localparam int COFM_W  = PROD_W;       // cofactor magnitude
    localparam int DP_W    = A_W + COF_W;  // row 0 entry times cofactor
    localparam int DET_W   = DP_W + 1;     // determinant, Q13.36
    localparam int MAG_W   = DET_W - 1;    // determinant magnitude
    localparam int B_W     = 24;           // output entry, Q11.12
    localparam int QB      = B_W + 2;      // quotient bits at twice the scale
    localparam int DIV_LAT = QB + 2;       // divider latency in cycles
    localparam int N_ENT   = 9;

    localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (B_W - 1)) - 64'd1);
    localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (B_W - 1));

endpackage

### hw/rtl/mi3_div.sv
// One lane of the pipelined divider: cofactor * 2^24 / determinant, rounded
// half away from zero and saturated to 24 bits. Uses mi3_pkg.
module mi3_div
    import mi3_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [COF_W-1:0] cof,
    input  logic signed [DET_W-1:0] det,
    output logic        [B_W-1:0]   code,
    output logic                    clip
);

    logic [MAG_W-1:0] rem_reg [0:QB];
    logic [MAG_W-1:0] den_reg [0:QB];
    logic [QB-1:0]    q_reg   [0:QB];
    logic             neg_reg [0:QB];
    logic             ovf_reg [0:QB];
    logic             lsb_reg;
    logic [B_W-1:0]   code_reg;
    logic             clip_reg;

    logic [COFM_W-1:0] cof_mag;
    logic [MAG_W-1:0]  det_mag;

    always_comb begin
        cof_mag = cof[COF_W-1] ? COFM_W'(-cof) : COFM_W'(cof);
        det_mag = det[DET_W-1] ? MAG_W'(-det) : MAG_W'(det);
    end

    // The dividend is |cof| << 25; its top part must already sit below the
    // divisor, otherwise the quotient cannot fit and the entry saturates.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= MAG_W'(cof_mag >> 1);
            den_reg[0] <= det_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= cof[COF_W-1] ^ det[DET_W-1];
            ovf_reg[0] <= MAG_W'(cof_mag >> 1) >= det_mag;
            lsb_reg    <= cof_mag[0];
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [MAG_W:0] trial;
        logic           fits;
        always_comb begin
            trial = {rem_reg[k], (k == 0) ? lsb_reg : 1'b0};
            fits  = trial >= {1'b0, den_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? MAG_W'(trial - {1'b0, den_reg[k]}) : MAG_W'(trial);
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], fits};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    logic [QB:0]   rsum;
    logic [QB-1:0] q;
    logic          neg;
    logic [B_W-1:0] code_next;
    logic           clip_next;

    always_comb begin
        rsum = {1'b0, q_reg[QB]} + (QB + 1)'(1);
        q    = rsum[QB:1];
        neg  = neg_reg[QB] && (ovf_reg[QB] || q != '0);
        clip_next = 1'b0;
        if (neg) begin
            if (ovf_reg[QB] || q > NEG_LIM) begin
                code_next = NEG_LIM[B_W-1:0];
                clip_next = 1'b1;
            end else begin
                code_next = (~q[B_W-1:0]) + B_W'(1);
            end
        end else begin
            if (ovf_reg[QB] || q > POS_LIM) begin
                code_next = POS_LIM[B_W-1:0];
                clip_next = 1'b1;
            end else begin
                code_next = q[B_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            code_reg <= code_next;
            clip_reg <= clip_next;
        end
    end

    assign code = code_reg;
    assign clip = clip_reg;

endmodule

### hw/rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate. A word of nine Q3.12 entries goes in,
// one word of nine saturated Q11.12 entries comes out, with tuser[0] set for a
// singular matrix (entries zero) and tuser[1] set when any entry saturated.
// A new matrix is taken every cycle unless the output stalls; each passes the
// input register, products, cofactors, row-0 products and determinant, then
// the restoring divider, one quotient bit per stage, to the output. The whole
// pipeline advances together, so a valid output word held by a low m_tready
// holds s_tready low; an empty output never stalls the input.
// Depends on mi3_pkg and mi3_div.
module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [N_ENT*A_W-1:0]   s_tdata,  // a00, a01, a02, a10 .. a22
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [N_ENT*B_W-1:0]   m_tdata,  // b00, b01, b02, b10 .. b22
    output logic [1:0]             m_tuser   // singular, clipped
);

    localparam int PRE_LAT = 5;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [PRE_LAT+DIV_LAT-1:0] vld_reg;
    logic [DIV_LAT-1:0]         sing_reg;

    logic signed [A_W-1:0]    a_reg   [0:N_ENT-1];
    logic signed [PROD_W-1:0] pp_reg  [0:N_ENT-1];
    logic signed [PROD_W-1:0] pn_reg  [0:N_ENT-1];
    logic signed [A_W-1:0]    r0b_reg [0:2];
    logic signed [A_W-1:0]    r0c_reg [0:2];
    logic signed [COF_W-1:0]  cof_reg [0:N_ENT-1];
    logic signed [COF_W-1:0]  cofd_reg[0:N_ENT-1];
    logic signed [COF_W-1:0]  cofe_reg[0:N_ENT-1];
    logic signed [DP_W-1:0]   dp_reg  [0:2];
    logic signed [DET_W-1:0]  det_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PRE_LAT+DIV_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int e = 0; e < N_ENT; e++) begin
                a_reg[e] <= s_tdata[e*A_W +: A_W];
            end
            // Cyclic indices put the cofactor sign into the minor itself.
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pp_reg[i*3+j] <= a_reg[((i+1)%3)*3 + (j+1)%3]
                                   * a_reg[((i+2)%3)*3 + (j+2)%3];
                    pn_reg[i*3+j] <= a_reg[((i+1)%3)*3 + (j+2)%3]
                                   * a_reg[((i+2)%3)*3 + (j+1)%3];
                end
            end
            for (int j = 0; j < 3; j++) begin
                r0b_reg[j] <= a_reg[j];
                r0c_reg[j] <= r0b_reg[j];
            end
            for (int e = 0; e < N_ENT; e++) begin
                cof_reg[e]  <= COF_W'(pp_reg[e]) - COF_W'(pn_reg[e]);
                cofd_reg[e] <= cof_reg[e];
                cofe_reg[e] <= cofd_reg[e];
            end
            for (int j = 0; j < 3; j++) begin
                dp_reg[j] <= DP_W'(r0c_reg[j]) * DP_W'(cof_reg[j]);
            end
            det_reg <= DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sing_reg <= {sing_reg[DIV_LAT-2:0], det_reg == '0};
        end
    end

    logic [B_W-1:0] code [0:N_ENT-1];
    logic [N_ENT-1:0] clips;

    // Output entry (i, j) divides the transposed cofactor (j, i).
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            mi3_div u_div (
                .aclk (aclk),
                .en   (en),
                .cof  (cofe_reg[j*3+i]),
                .det  (det_reg),
                .code (code[i*3+j]),
                .clip (clips[i*3+j])
            );
        end
    end

    logic sing;
    assign sing     = sing_reg[DIV_LAT-1];
    assign m_tvalid = vld_reg[PRE_LAT+DIV_LAT-1];

    always_comb begin
        for (int e = 0; e < N_ENT; e++) begin
            m_tdata[e*B_W +: B_W] = sing ? '0 : code[e];
        end
        m_tuser = {(|clips) && !sing, sing};
    end

endmodule

### hw/rtl/mi3_check.sv
// Port-level checks for matrix_inverse_3x3, attached by the bind below.
// Depends on mi3_pkg.
module mi3_check
    import mi3_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [N_ENT*B_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // With nothing waiting at the output the block always takes a word.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // A singular matrix gives zero entries and no saturation.
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("singular word with nonzero entries or clip");

    // A stalled word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind matrix_inverse_3x3 mi3_check u_mi3_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/mi3_checker.sv
`timescale 1ns / 100ps
// Checker for matrix_inverse_3x3: predicts each inverse from the accepted input
// word and compares it with the output word. Depends on mi3_pkg.
module mi3_checker
    import mi3_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [N_ENT*A_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [N_ENT*B_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [N_ENT*B_W-1:0] ent;
        logic                 singular;
        logic                 clipped;
    } inverse_t;

    inverse_t inverse_q[$];

    assign pending = inverse_q.size();

    // Rounded, saturated quotient of cof * 2^24 / det as a 24-bit code.
    function automatic logic [B_W-1:0] scaled_quotient(input longint cof, input longint det,
                                                       inout logic clip);
        longint unsigned num, den, q;
        bit neg;
        num = (cof < 0 ? -cof : cof) << 24;
        den = det < 0 ? -det : det;
        q   = (2 * num + den) / (2 * den);
        neg = ((cof < 0) != (det < 0)) && q != 0;
        if (neg) begin
            if (q > 64'd8388608) begin
                q = 64'd8388608;
                clip = 1'b1;
            end
            return B_W'(-q);
        end
        if (q > 64'd8388607) begin
            q = 64'd8388607;
            clip = 1'b1;
        end
        return B_W'(q);
    endfunction

    function automatic inverse_t invert(input logic [N_ENT*A_W-1:0] word);
        longint m[3][3];
        longint cof[3][3];
        longint det;
        inverse_t res;
        logic clip;
        det  = 0;
        clip = 1'b0;
        res  = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = longint'($signed(word[(i*3+j)*A_W +: A_W]));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                          - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
        for (int j = 0; j < 3; j++) det += m[0][j] * cof[0][j];
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        // The adjugate is the transposed cofactor matrix.
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res.ent[(i*3+j)*B_W +: B_W] = scaled_quotient(cof[j][i], det, clip);
        res.clipped = clip;
        return res;
    endfunction

    initial fail_count = 0;

    always @(posedge aclk) begin
        inverse_t exp_inv;
        if (aresetn) begin
            if (s_tvalid && s_tready) inverse_q.push_back(invert(s_tdata));
            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    $error("output word with no input pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_inv = inverse_q.pop_front();
                    for (int k = 0; k < N_ENT; k++)
                        if (m_tdata[k*B_W +: B_W] !== exp_inv.ent[k*B_W +: B_W]) begin
                            $error("b%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                                   $signed(exp_inv.ent[k*B_W +: B_W]),
                                   $signed(m_tdata[k*B_W +: B_W]));
                            fail_count++;
                        end
                    if (m_tuser[0] !== exp_inv.singular) begin
                        $error("singular: expected %0b, got %0b", exp_inv.singular, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== exp_inv.clipped) begin
                        $error("clipped: expected %0b, got %0b", exp_inv.clipped, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/tb_matrix_inverse_3x3.sv
`timescale 1ns / 100ps
// Top of the matrix_inverse_3x3 testbench: clock, reset, matrix stimulus and
// output backpressure. Depends on mi3_pkg, mi3_checker and the block itself.
module tb_matrix_inverse_3x3;
    import mi3_pkg::*;

    localparam int RANDOM_WORDS = 730;
    localparam int HOLD_CYCLES  = 120;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [N_ENT*A_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [N_ENT*B_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    int                   fail_count;
    int                   pending;
    logic                 calm = 1'b0;

    typedef logic signed [A_W-1:0] entry_t;
    typedef entry_t matrix_t [9];

    matrix_t directed_q[$];

    matrix_inverse_3x3 dut (.*);

    mi3_checker u_checker (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_matrix_inverse_3x3 failed");
        $finish;
    end

    function automatic entry_t rand_entry();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return entry_t'($urandom_range(0, 8191)) - 16'sd4096;
            4, 5:    return entry_t'($urandom_range(0, 255)) - 16'sd128;
            default: return entry_t'($urandom);
        endcase
    endfunction

    // Random matrices, with a share of singular and near-singular ones.
    function automatic matrix_t rand_matrix();
        matrix_t m;
        int kind;
        for (int k = 0; k < 9; k++) m[k] = rand_entry();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            for (int c = 0; c < 3; c++) m[6+c] = m[c];
        end else if (kind == 1) begin
            for (int c = 0; c < 3; c++)
                m[3+c] = entry_t'(m[c] + entry_t'($urandom_range(0, 2)) - 1);
        end else if (kind == 2) begin
            for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? rand_entry() : entry_t'(0);
        end
        return m;
    endfunction

    function automatic matrix_t mk(input int d0, input int d1, input int d2, input int d3,
                                   input int d4, input int d5, input int d6, input int d7,
                                   input int d8);
        matrix_t m;
        m = '{entry_t'(d0), entry_t'(d1), entry_t'(d2), entry_t'(d3), entry_t'(d4),
              entry_t'(d5), entry_t'(d6), entry_t'(d7), entry_t'(d8)};
        return m;
    endfunction

    task automatic send_matrix(input matrix_t m, input bit may_idle);
        logic [N_ENT*A_W-1:0] word;
        for (int k = 0; k < 9; k++) word[k*A_W +: A_W] = m[k];
        while (may_idle && !calm && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Receiver: random stalls, one long hold-off and a calm stretch.
    initial begin
        int word_cnt;
        word_cnt = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) word_cnt++;
            calm <= word_cnt > 300 && word_cnt < 420;
            if (word_cnt == 60) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                word_cnt++;
            end
            m_tready <= calm || $urandom_range(0, 99) >= 14;
        end
    end

    initial begin
        directed_q.push_back(mk(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
        directed_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        directed_q.push_back(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        directed_q.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
        directed_q.push_back(mk(-1, 0, 0, 0, 1, 0, 0, 0, -1));
        directed_q.push_back(mk(1, 2, 3, 4, 5, 6, 7, 8, 9));
        directed_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        directed_q.push_back(mk(0, 4096, 0, 0, 0, 4096, 4096, 0, 0));
        directed_q.push_back(mk(8192, 0, 0, 0, 8192, 0, 0, 0, 8192));
        // Small diagonal entries exercise rounding and saturation.
        directed_q.push_back(mk(3, 0, 0, 0, 1, 0, 0, 0, 1));
        directed_q.push_back(mk(-3, 0, 0, 0, 1, 0, 0, 0, 1));
        directed_q.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
                                -32768));
        directed_q.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, -32768,
                                32767, -32768));
        directed_q.push_back(mk(12288, -4096, 2048, 1024, 8192, -512, 0, 256, 4096));
        directed_q.push_back(mk(4096, 4096, 0, 4096, 4097, 0, 0, 0, 4096));
        directed_q.push_back(mk(21845, -21846, 1, 10922, -10923, 2, 5461, 5461, -5462));
        directed_q.push_back(mk(-21846, 21845, -2, -10923, 10922, -1, -5462, -5462, 5461));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_q[i]) send_matrix(directed_q[i], 1'b0);
        for (int n = 0; n < RANDOM_WORDS; n++) send_matrix(rand_matrix(), 1'b1);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DIV_LAT + 10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_matrix_inverse_3x3 passed");
        end else begin
            $display("tb_matrix_inverse_3x3 failed");
        end
        $finish;
    end

endmodule
